// ----- design/multiword_div_by_limb_preinv_core_macros.svh -----
// ----------------------------------------------------------------------------
// multiword divider assertion macros
// Shared concurrent assertion forms for the divider checker.
// ----------------------------------------------------------------------------
`ifndef MULTIWORD_DIV_BY_LIMB_PREINV_CORE_MACROS_SVH
`define MULTIWORD_DIV_BY_LIMB_PREINV_CORE_MACROS_SVH

// property checked only outside reset
`define MWD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define MWD_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/mwdiv_pkg.sv -----
// ----------------------------------------------------------------------------
// mwdiv_pkg
// Types and constants shared by the multiword limb divider.
// ----------------------------------------------------------------------------
package mwdiv_pkg;

	localparam int LIMB_W    = 64;
	localparam int HALF_W    = 32;
	localparam int CFG_IDX_W = 2;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_DIVISOR    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RECIPROCAL = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SHIFT      = 2'd2;

	// register reset values
	localparam logic [LIMB_W-1:0] DIVISOR_RST    = 64'd1;
	localparam logic [LIMB_W-1:0] RECIPROCAL_RST = '1;
	localparam logic [5:0]        SHIFT_RST      = 6'd63;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MULQ,
		ST_QEST,
		ST_QINC,
		ST_MULR,
		ST_REM,
		ST_FIX1,
		ST_FIX2,
		ST_OUT
	} seq_state_t;

	// what happens to a partial product in the cycle after its issue
	typedef enum logic [1:0] {
		ACC_NONE,
		ACC_ADD,
		ACC_SUB
	} acc_op_t;

	// partial product weight, in units of 32 bits
	typedef enum logic [1:0] {
		WT_0,
		WT_32,
		WT_64
	} acc_wt_t;

	// sequencer to datapath
	typedef struct packed {
		logic    in_ready;
		logic    use_r;
		logic    a_hi;
		logic    b_hi;
		acc_op_t acc_op;
		acc_wt_t acc_wt;
		logic    load_q1;
		logic    fix1;
		logic    fix2;
		logic    load_out;
	} seq_ctrl_t;

	// datapath to sequencer
	typedef struct packed {
		logic in_fire;
		logic out_free;
	} seq_stat_t;

endpackage

// ----- design/multiword_div_by_limb_preinv_core.sv -----
// ----------------------------------------------------------------------------
// multiword_div_by_limb_preinv_core
// Streaming multi-limb by single-limb divider with preinverted 2-by-1 step.
// ----------------------------------------------------------------------------
// Dividend limbs enter on the s_ beat channel, most significant first;
// s_tuser marks the top limb (clears the running remainder) and s_tlast
// the bottom one. Each beat gives one m_ beat: the quotient limb, and with
// m_tlast set the final remainder in the upper half of m_tdata.
// divisor, reciprocal and shift are loaded through cfg_we/cfg_index/cfg_data;
// the user must write them only while the block is idle; the block itself
// does not enforce this. A limb is not taken before the previous one is
// through; its result and s_tready show in the same cycle, as the sequencer
// leaves its output state. The pace is set by the single 32x32 multiplier,
// which issues four partial products for the quotient estimate and three
// for the remainder, plus the correction steps.
// s_tready is high only between limbs. A finished beat sits in the output
// register; a stalled receiver holds it, and the next limb may be taken and
// worked on, waiting at its end until the output register frees.
// Reset (arst_n low) restores the register defaults, clears the running
// remainder and empties the output register.
// ----------------------------------------------------------------------------
module multiword_div_by_limb_preinv_core
	import mwdiv_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration write port
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [LIMB_W-1:0]      cfg_data,
	// dividend limbs
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [LIMB_W-1:0]      s_tdata,   // [63:0] limb
	input  logic                   s_tuser,   // [0] first
	input  logic                   s_tlast,
	// quotient limbs
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [2*LIMB_W-1:0]    m_tdata,   // [63:0] quotient_limb, [127:64] remainder
	output logic                   m_tlast
);

	seq_ctrl_t ctrl;
	seq_stat_t stat;

	logic [LIMB_W-1:0]   divisor_q, reciprocal_q;
	logic [5:0]          shift_q, sh_q;
	logic [LIMB_W-1:0]   pr_q;
	logic [LIMB_W-1:0]   dn_q, u0_q, u1_q, q1_q, r_q;
	logic [2*LIMB_W-1:0] acc_q;
	logic                last_q;
	acc_op_t             acc_op_s1;
	acc_wt_t             acc_wt_s1;
	logic                out_valid_q;
	logic [LIMB_W-1:0]   quot_q, rem_q;
	logic                fin_q;

	logic                in_fire;
	logic [2*LIMB_W-1:0] limb_ext;
	logic [LIMB_W-1:0]   u1_new;
	logic [HALF_W-1:0]   mul_a, mul_b;
	logic [LIMB_W-1:0]   p_q;
	logic [2*LIMB_W-1:0] p_wt;

	assign in_fire       = s_tvalid && s_tready;
	assign s_tready      = ctrl.in_ready;
	assign stat.in_fire  = in_fire;
	assign stat.out_free = !out_valid_q || m_tready;

	mwdiv_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			divisor_q    <= DIVISOR_RST;
			reciprocal_q <= RECIPROCAL_RST;
			shift_q      <= SHIFT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DIVISOR:    divisor_q    <= cfg_data;
				REG_RECIPROCAL: reciprocal_q <= cfg_data;
				REG_SHIFT:      shift_q      <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	// normalise the incoming limb; upper word holds the bits shifted out
	assign limb_ext = {{LIMB_W{1'b0}}, s_tdata} << shift_q;
	assign u1_new   = (s_tuser ? '0 : pr_q) + limb_ext[2*LIMB_W-1:LIMB_W];

	// operand selection for the shared multiplier
	always_comb begin
		if (ctrl.use_r) begin
			mul_a = ctrl.a_hi ? q1_q[LIMB_W-1:HALF_W] : q1_q[HALF_W-1:0];
			mul_b = ctrl.b_hi ? dn_q[LIMB_W-1:HALF_W] : dn_q[HALF_W-1:0];
		end else begin
			mul_a = ctrl.a_hi ? u1_q[LIMB_W-1:HALF_W] : u1_q[HALF_W-1:0];
			mul_b = ctrl.b_hi ? reciprocal_q[LIMB_W-1:HALF_W]
			                  : reciprocal_q[HALF_W-1:0];
		end
	end

	mwdiv_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (p_q)
	);

	// accumulate op is registered to line up with its registered partial product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_op_s1 <= ACC_NONE;
			acc_wt_s1 <= WT_0;
		end else begin
			acc_op_s1 <= ctrl.acc_op;
			acc_wt_s1 <= ctrl.acc_wt;
		end
	end

	// place the partial product at its weight
	always_comb begin
		unique case (acc_wt_s1)
			WT_0:    p_wt = {{LIMB_W{1'b0}}, p_q};
			WT_32:   p_wt = {{HALF_W{1'b0}}, p_q, {HALF_W{1'b0}}};
			WT_64:   p_wt = {p_q, {LIMB_W{1'b0}}};
			default: p_wt = '0;
		endcase
	end

	// limb datapath: estimate, remainder and corrections
	always_ff @(posedge clk) begin
		if (in_fire) begin
			dn_q   <= divisor_q << shift_q;
			u0_q   <= limb_ext[LIMB_W-1:0];
			u1_q   <= u1_new;
			acc_q  <= {u1_new, limb_ext[LIMB_W-1:0]};
			last_q <= s_tlast;
			sh_q   <= shift_q;
		end else if (acc_op_s1 == ACC_ADD) begin
			acc_q <= acc_q + p_wt;
		end
		if (acc_op_s1 == ACC_SUB) begin
			r_q <= r_q - p_wt[LIMB_W-1:0];
		end else if (ctrl.load_q1) begin
			q1_q <= acc_q[2*LIMB_W-1:LIMB_W] + 64'd1;
			r_q  <= u0_q;
		end else if (ctrl.fix1) begin
			if (r_q >= acc_q[LIMB_W-1:0]) begin
				q1_q <= q1_q - 64'd1;
				r_q  <= r_q + dn_q;
			end
		end else if (ctrl.fix2) begin
			if (r_q >= dn_q) begin
				q1_q <= q1_q + 64'd1;
				r_q  <= r_q - dn_q;
			end
		end
	end

	// running remainder and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pr_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctrl.load_out) begin
				pr_q        <= r_q;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output beat register
	always_ff @(posedge clk) begin
		if (ctrl.load_out) begin
			quot_q <= q1_q;
			rem_q  <= last_q ? (r_q >> sh_q) : '0;
			fin_q  <= last_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {rem_q, quot_q};
	assign m_tlast  = fin_q;

endmodule

// ----- design/mwdiv_mul.sv -----
// ----------------------------------------------------------------------------
// mwdiv_mul
// Shared 32x32 unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module mwdiv_mul
	import mwdiv_pkg::*;
(
	input  logic                clk,
	input  logic [HALF_W-1:0]   a,
	input  logic [HALF_W-1:0]   b,
	output logic [LIMB_W-1:0]   p_q
);

	// one partial product per cycle
	always_ff @(posedge clk) begin
		p_q <= LIMB_W'(a) * LIMB_W'(b);
	end

endmodule

// ----- design/mwdiv_seq.sv -----
// ----------------------------------------------------------------------------
// mwdiv_seq
// Sequencer that steps one limb through the shared multiplier.
// ----------------------------------------------------------------------------
module mwdiv_seq
	import mwdiv_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  seq_stat_t stat,
	output seq_ctrl_t ctrl
);

	seq_state_t state_q, state_d;
	logic [1:0] cnt_q, cnt_d;

	// state and partial counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= 2'd0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		cnt_d   = 2'd0;
		unique case (state_q)
			ST_IDLE: if (stat.in_fire) state_d = ST_MULQ;
			ST_MULQ: begin
				if (cnt_q == 2'd3) state_d = ST_QEST;
				else cnt_d = cnt_q + 2'd1;
			end
			ST_QEST: state_d = ST_QINC;
			ST_QINC: state_d = ST_MULR;
			ST_MULR: begin
				if (cnt_q == 2'd2) state_d = ST_REM;
				else cnt_d = cnt_q + 2'd1;
			end
			ST_REM:  state_d = ST_FIX1;
			ST_FIX1: state_d = ST_FIX2;
			ST_FIX2: state_d = ST_OUT;
			ST_OUT:  if (stat.out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		ctrl          = '0;
		ctrl.acc_op   = ACC_NONE;
		ctrl.acc_wt   = WT_0;
		// partial weights: lo*lo, lo*hi, hi*lo, hi*hi
		ctrl.a_hi     = cnt_q[1];
		ctrl.b_hi     = cnt_q[0];
		if (cnt_q == 2'd3) ctrl.acc_wt = WT_64;
		else if (cnt_q != 2'd0) ctrl.acc_wt = WT_32;
		unique case (state_q)
			ST_IDLE: ctrl.in_ready = 1'b1;
			ST_MULQ: ctrl.acc_op   = ACC_ADD;
			ST_MULR: begin
				ctrl.use_r  = 1'b1;
				ctrl.acc_op = ACC_SUB;
			end
			ST_QINC: ctrl.load_q1  = 1'b1;
			ST_FIX1: ctrl.fix1     = 1'b1;
			ST_FIX2: ctrl.fix2     = 1'b1;
			ST_OUT:  ctrl.load_out = stat.out_free;
			default: ;
		endcase
	end

endmodule

// ----- design/mwdiv_checker.sv -----
// ----------------------------------------------------------------------------
// mwdiv_checker
// Port-level checks on the multiword limb divider, bound to the top level.
// ----------------------------------------------------------------------------
`include "multiword_div_by_limb_preinv_core_macros.svh"

module mwdiv_checker
	import mwdiv_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_tvalid,
	input logic                   s_tready,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [2*LIMB_W-1:0]    m_tdata,
	input logic                   m_tlast
);

	// a stalled result beat holds
	`MWD_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast), "result beat changed while stalled")

	// remainder field is zero except on the bottom limb
	`MWD_ASSERT(a_rem_zero, m_tvalid && !m_tlast |-> m_tdata[2*LIMB_W-1:LIMB_W] == '0, "remainder nonzero on a non-final beat")

	// one limb at a time: the input closes after each beat
	`MWD_ASSERT(a_one_limb, s_tvalid && s_tready |=> !s_tready, "input still ready after a beat")

	// no result beat once reset has been seen
	`MWD_ASSERT_ALWAYS(a_rst_empty, !arst_n |=> !m_tvalid, "result valid after reset")

endmodule

bind multiword_div_by_limb_preinv_core mwdiv_checker u_mwdiv_checker (.*);

// ----- dv/mwdiv_quotient_checker.sv -----
// ----------------------------------------------------------------------------
// mwdiv_quotient_checker
// Watches the limb divider's channels, predicts each quotient beat and
// compares it field by field against what the block produces.
// ----------------------------------------------------------------------------
module mwdiv_quotient_checker
	import mwdiv_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [LIMB_W-1:0]    cfg_data,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [LIMB_W-1:0]    s_tdata,   // [63:0] limb
	input  logic                 s_tuser,   // [0] first
	input  logic                 s_tlast,
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [2*LIMB_W-1:0]  m_tdata,   // [63:0] quotient_limb, [127:64] remainder
	input  logic                 m_tlast,
	output int                   fail_count,
	output int                   outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [LIMB_W-1:0] quot;
		logic [LIMB_W-1:0] rem;
		logic              fin;
	} div_result_t;

	// mirrored registers and running normalised remainder
	logic [LIMB_W-1:0] divisor_q;
	logic [LIMB_W-1:0] recip_q;
	logic [5:0]        shift_q;
	logic [LIMB_W-1:0] running_rem;

	div_result_t       pending_quotients[$];
	div_result_t       want;
	div_result_t       got;
	logic [LIMB_W-1:0] next_rem;

	// one preinverted 2-by-1 step; the product with the reciprocal is taken at 128 bits, all else wraps at 64 bits
	function automatic div_result_t divide_limb(
		input  logic [LIMB_W-1:0] dvsr,
		input  logic [LIMB_W-1:0] recip,
		input  logic [5:0]        sh,
		input  logic [LIMB_W-1:0] prev_rem,
		input  logic [LIMB_W-1:0] limb,
		input  logic              is_last,
		output logic [LIMB_W-1:0] rem_out
	);
		logic [LIMB_W-1:0]   dn, u0, u1, qh, ql, q1, r;
		logic [2*LIMB_W-1:0] prod;
		div_result_t         res;
		dn = dvsr << sh;
		u0 = limb << sh;
		u1 = prev_rem;
		// bits shifted out of the limb join the remainder, none at shift zero
		if (sh != 6'd0)
			u1 = u1 + (limb >> (LIMB_W - sh));
		prod = {{LIMB_W{1'b0}}, u1} * {{LIMB_W{1'b0}}, recip};
		qh = prod[2*LIMB_W-1:LIMB_W];
		ql = prod[LIMB_W-1:0];
		ql = ql + u0;
		qh = qh + u1 + {{(LIMB_W-1){1'b0}}, (ql < u0)};
		q1 = qh + 64'd1;
		r  = u0 - q1 * dn;
		// up to two corrections of the estimate
		if (r >= ql) begin
			q1 = q1 - 64'd1;
			r  = r + dn;
		end
		if (r >= dn) begin
			q1 = q1 + 64'd1;
			r  = r - dn;
		end
		rem_out  = r;
		res.quot = q1;
		res.rem  = is_last ? (r >> sh) : '0;
		res.fin  = is_last;
		return res;
	endfunction

	// observe beats and register writes on every rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			divisor_q   = DIVISOR_RST;
			recip_q     = RECIPROCAL_RST;
			shift_q     = SHIFT_RST;
			running_rem = '0;
			pending_quotients.delete();
			fail_count  = 0;
		end else begin
			// result beat against the oldest prediction
			if (m_tvalid && m_tready) begin
				got.quot = m_tdata[LIMB_W-1:0];
				got.rem  = m_tdata[2*LIMB_W-1:LIMB_W];
				got.fin  = m_tlast;
				if (pending_quotients.size() == 0) begin
					$display("%0t: unexpected beat, quotient %h remainder %h last %b",
						$time, got.quot, got.rem, got.fin);
					fail_count++;
				end else begin
					want = pending_quotients.pop_front();
					if (got.quot !== want.quot) begin
						$display("%0t: quotient limb expected %h got %h",
							$time, want.quot, got.quot);
						fail_count++;
					end
					if (got.rem !== want.rem) begin
						$display("%0t: remainder expected %h got %h",
							$time, want.rem, got.rem);
						fail_count++;
					end
					if (got.fin !== want.fin) begin
						$display("%0t: last flag expected %b got %b",
							$time, want.fin, got.fin);
						fail_count++;
					end
				end
			end
			// register writes, unknown indexes ignored
			if (cfg_we) begin
				case (cfg_index)
					REG_DIVISOR:    divisor_q = cfg_data;
					REG_RECIPROCAL: recip_q   = cfg_data;
					REG_SHIFT:      shift_q   = cfg_data[5:0];
					default:        ;
				endcase
			end
			// accepted limb gives one prediction
			if (s_tvalid && s_tready) begin
				pending_quotients.push_back(divide_limb(divisor_q, recip_q, shift_q,
					s_tuser ? '0 : running_rem, s_tdata, s_tlast, next_rem));
				running_rem = next_rem;
			end
		end
		outstanding = pending_quotients.size();
	end

endmodule

// ----- dv/multiword_div_by_limb_preinv_core_tb.sv -----
// ----------------------------------------------------------------------------
// multiword_div_by_limb_preinv_core_tb
// Streams multi-limb dividends through the limb divider under a range of
// divisor settings, with bursty input and a stalling receiver; the checker
// beside the block predicts and compares every quotient beat.
// ----------------------------------------------------------------------------
module multiword_div_by_limb_preinv_core_tb
	import mwdiv_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASE_LIMBS = 50;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef enum {
		DV_ONE,
		DV_ALL_ONES,
		DV_TOP_BIT,
		DV_FULL,
		DV_NARROW,
		DV_POW2,
		DV_GARBAGE,
		DV_ZERO
	} divisor_kind_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [LIMB_W-1:0]    cfg_data  = '0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [LIMB_W-1:0]    s_tdata   = '0;
	logic                 s_tuser   = 1'b0;
	logic                 s_tlast   = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [2*LIMB_W-1:0]  m_tdata;
	logic                 m_tlast;

	int   fail_count;
	int   outstanding;
	int   cycle_count = 0;
	int   burst_left  = 0;
	int   rx_mode     = 0;
	int   rx_left     = 0;
	logic s_taken     = 1'b0;

	multiword_div_by_limb_preinv_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	mwdiv_quotient_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.s_tlast     (s_tlast),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tlast     (m_tlast),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	// 8 ns clock
	always #4 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("multiword_div_by_limb_preinv_core_tb failed");
			$finish;
		end
	end

	// input beat taken at this edge, read back at the falling edge
	always @(posedge clk)
		s_taken <= s_tvalid && s_tready;

	// receiver stalls: free-running, coin-toss and mostly-stalled stretches
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode <= $urandom_range(0, 2);
			rx_left <= $urandom_range(20, 200);
		end else begin
			rx_left <= rx_left - 1;
		end
		case (rx_mode)
			0:       m_tready <= 1'b1;
			1:       m_tready <= 1'($urandom_range(0, 1));
			default: m_tready <= ($urandom_range(0, 5) == 0);
		endcase
	end

	// one limb beat, sent in bursts with random gaps between them
	task automatic send_limb(input logic [LIMB_W-1:0] limb, input logic first,
		input logic last);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 12);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 10);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= limb;
		s_tuser  <= first;
		s_tlast  <= last;
		do @(negedge clk); while (s_taken !== 1'b1);
	endtask

	// stop sending and wait for every predicted beat to arrive
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LIMB_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
	endtask

	// load a divisor with matching shift and reciprocal, or junk on request
	task automatic configure(input divisor_kind_t kind);
		logic [LIMB_W-1:0]   dvsr, recip;
		logic [2*LIMB_W-1:0] quo;
		logic [5:0]          sh;
		case (kind)
			DV_ONE:      dvsr = 64'd1;
			DV_ALL_ONES: dvsr = '1;
			DV_TOP_BIT:  dvsr = 64'h8000_0000_0000_0000;
			DV_NARROW:   dvsr = 64'($urandom_range(1, 65535));
			DV_POW2:     dvsr = 64'd1 << $urandom_range(0, 63);
			DV_ZERO:     dvsr = '0;
			default:     dvsr = {$urandom(), $urandom()} | 64'd1;
		endcase
		sh = 6'd0;
		for (int b = LIMB_W - 1; b >= 0 && !dvsr[b]; b--)
			sh = sh + 6'd1;
		quo   = {(2*LIMB_W){1'b1}} / {{LIMB_W{1'b0}}, dvsr << sh};
		recip = quo[LIMB_W-1:0];
		// inconsistent registers: results fixed but meaningless
		if (kind == DV_GARBAGE || kind == DV_ZERO) begin
			recip = {$urandom(), $urandom()};
			sh    = 6'($urandom_range(0, 63));
		end
		write_reg(REG_UNUSED, {$urandom(), $urandom()});
		write_reg(REG_SHIFT, {$urandom(), $urandom()} & ~64'h3f | 64'(sh));
		write_reg(REG_RECIPROCAL, recip);
		write_reg(REG_DIVISOR, dvsr);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// one dividend, mostly well formed, sometimes with flags dropped or scrambled
	task automatic send_dividend(output int count);
		int                len, noise;
		logic              first, last;
		logic [LIMB_W-1:0] limb;
		len   = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 4);
		noise = $urandom_range(0, 9);
		for (int i = 0; i < len; i++) begin
			first = (i == 0);
			last  = (i == len - 1);
			case (noise)
				0: begin
					first = 1'($urandom_range(0, 1));
					last  = 1'($urandom_range(0, 1));
				end
				1: if (i == 0) first = 1'b0;
				2: last = 1'b0;
				default: ;
			endcase
			case ($urandom_range(0, 7))
				0:       limb = '0;
				1:       limb = '1;
				2:       limb = 64'($urandom_range(0, 255));
				3:       limb = {$urandom(), $urandom()} >> $urandom_range(0, 63);
				4:       limb = ~({$urandom(), $urandom()} >> $urandom_range(0, 63));
				default: limb = {$urandom(), $urandom()};
			endcase
			send_limb(limb, first, last);
		end
		count = len;
	endtask

	// stimulus and verdict
	initial begin
		int sent, n;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset registers: divisor one, normalised by 63
		send_limb('0, 1'b1, 1'b1);
		send_limb('1, 1'b1, 1'b1);
		send_limb('1, 1'b1, 1'b0);
		send_limb('1, 1'b0, 1'b0);
		send_limb('1, 1'b0, 1'b1);
		// no first flag: remainder carries over the previous last limb
		send_limb(64'h8000_0000_0000_0000, 1'b0, 1'b1);
		drain();

		// largest divisor, shift zero
		configure(DV_ALL_ONES);
		send_limb('1, 1'b1, 1'b0);
		send_limb('1, 1'b0, 1'b0);
		send_limb('0, 1'b0, 1'b0);
		send_limb(64'd1, 1'b0, 1'b1);
		// first flag in the middle of a run restarts it
		send_limb(64'hffff_ffff_ffff_fffe, 1'b1, 1'b0);
		send_limb('1, 1'b1, 1'b1);
		drain();

		// top bit alone, shift zero with all-ones reciprocal
		configure(DV_TOP_BIT);
		send_limb('1, 1'b1, 1'b0);
		send_limb(64'h7fff_ffff_ffff_ffff, 1'b0, 1'b1);
		send_limb('0, 1'b1, 1'b1);
		drain();

		// random dividends across divisor settings
		for (int k = DV_ONE; k <= DV_ZERO; k++) begin
			configure(divisor_kind_t'(k));
			sent = 0;
			while (sent < PHASE_LIMBS) begin
				send_dividend(n);
				sent += n;
			end
			drain();
		end

		repeat (16) @(posedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("multiword_div_by_limb_preinv_core_tb passed");
		else
			$display("multiword_div_by_limb_preinv_core_tb failed");
		$finish;
	end

endmodule
